/* rtl/ice_pkg.sv */
`default_nettype none

package ice_pkg;

  localparam int unsigned WordBits = 16;
  localparam int unsigned ByteBits = 8;

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_SUB = 1'b1;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [ByteBits-1:0] byte_t;

  typedef struct packed {
    word_t sum;
    word_t pad;
  } fold_t;

  function automatic word_t ones_add(input word_t a, input word_t b);
    logic [WordBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WordBits-1:0] + {{(WordBits-1){1'b0}}, s[WordBits]};
  endfunction

endpackage

`default_nettype wire

/* rtl/ice_accum.sv */
`default_nettype none

module ice_accum
  import ice_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic        kind,
  input  wire logic [15:0] data_word,
  input  wire logic [1:0]  byte_count,
  input  wire logic        last,
  output fold_t            fold
);

  word_t accumulator;
  byte_t held_byte;
  logic  held_valid;

  word_t accumulator_next;
  byte_t held_byte_next;
  logic  held_valid_next;
  logic  add_en;
  word_t add_word;
  byte_t hi_byte;
  byte_t lo_byte;

  assign hi_byte = data_word[15:8];
  assign lo_byte = data_word[7:0];

  always_comb begin
    add_en          = 1'b0;
    add_word        = '0;
    held_byte_next  = held_byte;
    held_valid_next = held_valid;
    if (kind == KIND_SUB) begin
      add_en   = 1'b1;
      add_word = ~data_word;
    end else if (byte_count == 2'd1) begin
      if (held_valid) begin
        add_en          = 1'b1;
        add_word        = {held_byte, hi_byte};
        held_byte_next  = '0;
        held_valid_next = 1'b0;
      end else begin
        held_byte_next  = hi_byte;
        held_valid_next = 1'b1;
      end
    end else if (byte_count != 2'd0) begin
      add_en = 1'b1;
      if (held_valid) begin
        add_word       = {held_byte, hi_byte};
        held_byte_next = lo_byte;
      end else begin
        add_word = data_word;
      end
    end
    accumulator_next = add_en ? ones_add(accumulator, add_word) : accumulator;
  end

  assign fold = {accumulator_next,
                 held_valid_next ? {held_byte_next, {ByteBits{1'b0}}} : word_t'(0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      held_byte   <= '0;
      held_valid  <= 1'b0;
    end else if (take) begin
      if (last) begin
        accumulator <= '0;
        held_byte   <= '0;
        held_valid  <= 1'b0;
      end else begin
        accumulator <= accumulator_next;
        held_byte   <= held_byte_next;
        held_valid  <= held_valid_next;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/internet_checksum_engine.sv */
`default_nettype none

// Computes the Internet checksum over a stream of network-order bytes, one input beat
// per clock unless the input is stalled: add beats carry one or two bytes (a lone byte
// is held and paired with the next), subtract beats fold in the complement of a whole
// word to seed from an old checksum or remove an old field, and a beat with last set
// emits the complemented sum and clears the state for the next message. Beats are
// summed by the single end-around carry add in the accumulator loop. The finishing
// pad add sits in a stage of its own: the fold of the last beat is registered in that
// stage and the complemented sum in the output register. The input stalls only while
// that stage and the output register both hold a checksum and the output is stalled.

module internet_checksum_engine
  import ice_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [15:0] data_word,
  input  wire logic [1:0]  byte_count,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      checksum
);

  fold_t fold;
  fold_t fin;
  logic  fin_valid;
  logic  take;
  logic  out_free;
  logic  fin_free;

  assign out_free = !out_valid || !out_stall;
  assign fin_free = !fin_valid || out_free;
  assign in_stall = !fin_free;
  assign take     = in_valid && !in_stall;

  ice_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .kind       (kind),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .fold       (fold)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_free) begin
      fin_valid <= take && last;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_free && take && last) begin
      fin <= fold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && fin_valid) begin
      checksum <= ~ones_add(fin.sum, fin.pad);
    end
  end

endmodule

`default_nettype wire

/* rtl/ice_checker.sv */
`default_nettype none

module ice_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        last,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] checksum
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(checksum))
    else $error("Stalled output beat changed or dropped.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled while the output is free.");

  a_last_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && last) ##1 !out_stall |=> out_valid)
    else $error("Checksum did not appear after the last beat.");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("Output or stall active after reset.");

endmodule

bind internet_checksum_engine ice_checker u_ice_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .last      (last),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .checksum  (checksum)
);

`default_nettype wire
